// ----- sv/cpa_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the contiguous page allocator
package cpa_pkg;

    localparam int DEF_NUM_PAGES = 1024;
    localparam int FRAME_W       = 20;
    localparam int COUNT_W       = 11;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 2;

    localparam logic [COUNT_W-1:0] TOTAL_RESET = 11'd1024;
    localparam logic [COUNT_W-1:0] FIXED_RESET = 11'd0;
    localparam logic [FRAME_W-1:0] BASE_RESET  = 20'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC      = 2'd0,
        FUNC_FREE_BLOCK = 2'd1,
        FUNC_FREE_ONE   = 2'd2,
        FUNC_COUNT      = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_PAGES = 2'd0,
        CFG_FIXED_PAGES = 2'd1,
        CFG_BASE_FRAME  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_LOOKUP,
        ST_WALK,
        ST_COUNT,
        ST_DONE
    } state_t;

    // write enables of the page map
    typedef struct packed {
        logic used_we;
        logic used_val;
        logic blk_we;
    } map_we_t;

endpackage

// ----- sv/cpa_page_map.sv -----
`timescale 1ns / 1ps
// page map storage: used bits and block start indexes, one read and one write port
module cpa_page_map #(
    parameter int NUM_PAGES = cpa_pkg::DEF_NUM_PAGES
) (
    input  logic                         clk,
    input  logic [$clog2(NUM_PAGES)-1:0] rd_addr,
    output logic                         rd_used,
    output logic [$clog2(NUM_PAGES)-1:0] rd_blk,
    input  logic [$clog2(NUM_PAGES)-1:0] wr_addr,
    input  cpa_pkg::map_we_t             we,
    input  logic [$clog2(NUM_PAGES)-1:0] wr_blk
);
    import cpa_pkg::*;

    localparam int PW = $clog2(NUM_PAGES);

    logic          used_mem [NUM_PAGES];
    logic [PW-1:0] blk_mem  [NUM_PAGES];
    logic          rd_used_reg;
    logic [PW-1:0] rd_blk_reg;

    always_ff @(posedge clk)
    begin
        if (we.used_we)
        begin
            used_mem[wr_addr] <= we.used_val;
        end
        if (we.blk_we)
        begin
            blk_mem[wr_addr] <= wr_blk;
        end
        rd_used_reg <= used_mem[rd_addr];
        rd_blk_reg  <= blk_mem[rd_addr];
    end

    assign rd_used = rd_used_reg;
    assign rd_blk  = rd_blk_reg;

endmodule

// ----- sv/contiguous_page_allocator_core.sv -----
`timescale 1ns / 1ps
// contiguous page allocator: first-fit run allocation, block or single-page free and free count over a page map
//
//  channel  signals                                   direction  moves
//  -------  ----------------------------------------  ---------  ------------------------
//  in       in_valid, in_stall, func, page_count,     in         one request word
//           frame
//  out      out_valid, out_stall, ok, start_frame,    out        one result word per request
//           free_count
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in         one register write word
//
// after reset a clearing pass writes every map entry while in_stall is high; requests are taken
// one word at a time; each memory pass handles one page per cycle; scan, walk, recount read the map
// allocate: scan for the first fitting run, mark the wanted pages, then recount the free pages
// free: lookup, then a block walk for a block free, then recount; count: recount only
// the scan, walk and recount passes cover total_pages capped at NUM_PAGES
// the result register frees the input side: a new word is taken while out_stall holds a result
module contiguous_page_allocator_core #(
    parameter int NUM_PAGES = cpa_pkg::DEF_NUM_PAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cpa_pkg::FUNC_W-1:0]      func,
    input  logic [cpa_pkg::COUNT_W-1:0]     page_count,
    input  logic [cpa_pkg::FRAME_W-1:0]     frame,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            ok,
    output logic [cpa_pkg::FRAME_W-1:0]     start_frame,
    output logic [cpa_pkg::COUNT_W-1:0]     free_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpa_pkg::FRAME_W-1:0]     cfg_data
);
    import cpa_pkg::*;

    localparam int PW   = $clog2(NUM_PAGES);
    localparam int NW   = PW + 1;
    localparam int CMPW = (NW > COUNT_W) ? NW : COUNT_W;

    // configuration registers
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] fixed_reg;
    logic [FRAME_W-1:0] base_reg;

    // control
    state_t         state_reg,     state_next;
    logic [NW-1:0]  iss_reg,       iss_next;      // issue / write pointer
    logic           pv_reg,        pv_next;       // read data in flight is valid
    logic [PW-1:0]  pidx_reg,      pidx_next;     // page index of the read data
    logic           first_reg,     first_next;    // first page of a block walk
    logic           out_valid_reg, out_valid_next;

    // operation payload
    func_t              func_reg,      func_next;
    logic [COUNT_W-1:0] want_reg,      want_next;
    logic [FRAME_W-1:0] frame_reg,     frame_next;
    logic [CMPW-1:0]    run_reg,       run_next;
    logic [PW-1:0]      start_reg,     start_next;
    logic [PW-1:0]      last_reg,      last_next;
    logic [PW-1:0]      tag_reg,       tag_next;
    logic               ok_reg,        ok_next;
    logic [CMPW-1:0]    cnt_reg,       cnt_next;
    logic               out_ok_reg,    out_ok_next;
    logic [FRAME_W-1:0] out_start_reg, out_start_next;
    logic [COUNT_W-1:0] out_free_reg,  out_free_next;

    // page map port signals
    logic          map_used;
    logic [PW-1:0] map_blk;
    logic [PW-1:0] wr_addr;
    logic [PW-1:0] wr_blk;
    map_we_t       map_we;
    logic          rd_en;

    // derived values
    logic [CMPW-1:0]    total_ext;
    logic [CMPW-1:0]    eff_wide;
    logic [NW-1:0]      eff_n;
    logic [CMPW-1:0]    fixed_ext;
    logic               iss_live;
    logic               page_free;
    logic [CMPW-1:0]    run_inc;
    logic               hit;
    logic [PW-1:0]      start_eff;
    logic [FRAME_W-1:0] offset;
    logic               lk_ok;
    logic [PW-1:0]      lk_idx;
    logic [PW-1:0]      tag_eff;

    cpa_page_map #(
        .NUM_PAGES (NUM_PAGES)
    ) u_map (
        .clk     (clk),
        .rd_addr (iss_reg[PW-1:0]),
        .rd_used (map_used),
        .rd_blk  (map_blk),
        .wr_addr (wr_addr),
        .we      (map_we),
        .wr_blk  (wr_blk)
    );

    // effective total is total_pages capped at the map size
    assign total_ext = CMPW'(total_reg);
    assign eff_wide  = (total_ext >= CMPW'(NUM_PAGES)) ? CMPW'(NUM_PAGES) : total_ext;
    assign eff_n     = eff_wide[NW-1:0];
    assign fixed_ext = CMPW'(fixed_reg);
    assign iss_live  = (iss_reg < eff_n);

    // free page: below the total (guaranteed by issue), not fixed, not marked
    assign page_free = pv_reg && (CMPW'(pidx_reg) >= fixed_ext) && !map_used;
    assign run_inc   = run_reg + CMPW'(1);
    assign hit       = page_free && (run_inc == CMPW'(want_reg));
    assign start_eff = (run_reg == '0) ? pidx_reg : start_reg;

    // frame to page index lookup
    assign offset = frame_reg - base_reg;
    assign lk_ok  = (offset < FRAME_W'(eff_n)) && (offset >= FRAME_W'(fixed_reg));
    assign lk_idx = offset[PW-1:0];

    assign tag_eff = first_reg ? map_blk : tag_reg;

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        pidx_next      = pidx_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        want_next      = want_reg;
        frame_next     = frame_reg;
        run_next       = run_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        tag_next       = tag_reg;
        ok_next        = ok_reg;
        cnt_next       = cnt_reg;
        out_ok_next    = out_ok_reg;
        out_start_next = out_start_reg;
        out_free_next  = out_free_reg;
        rd_en          = 1'b0;
        map_we         = '0;
        wr_addr        = iss_reg[PW-1:0];
        wr_blk         = start_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                map_we = '{used_we: 1'b1, used_val: 1'b0, blk_we: 1'b1};
                wr_blk = '0;
                if (iss_reg == NW'(NUM_PAGES - 1))
                begin
                    iss_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    iss_next = iss_reg + NW'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func_t'(func);
                    want_next  = page_count;
                    frame_next = frame;
                    iss_next   = '0;
                    run_next   = '0;
                    cnt_next   = '0;
                    ok_next    = 1'b0;
                    case (func_t'(func))
                        FUNC_ALLOC:
                        begin
                            // zero pages never fits
                            state_next = (page_count == '0) ? ST_COUNT : ST_SCAN;
                        end
                        FUNC_FREE_BLOCK, FUNC_FREE_ONE:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        FUNC_COUNT:
                        begin
                            ok_next    = 1'b1;
                            state_next = ST_COUNT;
                        end
                        default:
                        begin
                            state_next = ST_COUNT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                rd_en = iss_live;
                if (rd_en)
                begin
                    iss_next = iss_reg + NW'(1);
                end
                if (pv_reg)
                begin
                    if (page_free)
                    begin
                        start_next = start_eff;
                        run_next   = run_inc;
                        if (hit)
                        begin
                            last_next  = pidx_reg;
                            iss_next   = NW'(start_eff);
                            state_next = ST_MARK;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                else if (!iss_live)
                begin
                    // no run fits
                    iss_next   = '0;
                    state_next = ST_COUNT;
                end
            end

            ST_MARK:
            begin
                map_we = '{used_we: 1'b1, used_val: 1'b1, blk_we: 1'b1};
                wr_blk = start_reg;
                iss_next = iss_reg + NW'(1);
                if (iss_reg[PW-1:0] == last_reg)
                begin
                    ok_next    = 1'b1;
                    iss_next   = '0;
                    state_next = ST_COUNT;
                end
            end

            ST_LOOKUP:
            begin
                if (!lk_ok)
                begin
                    iss_next   = '0;
                    state_next = ST_COUNT;
                end
                else if (func_reg == FUNC_FREE_ONE)
                begin
                    ok_next    = 1'b1;
                    map_we     = '{used_we: 1'b1, used_val: 1'b0, blk_we: 1'b0};
                    wr_addr    = lk_idx;
                    iss_next   = '0;
                    state_next = ST_COUNT;
                end
                else
                begin
                    ok_next    = 1'b1;
                    first_next = 1'b1;
                    iss_next   = NW'(lk_idx);
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                rd_en = iss_live;
                if (rd_en)
                begin
                    iss_next = iss_reg + NW'(1);
                end
                if (pv_reg)
                begin
                    if (first_reg || (map_blk == tag_reg))
                    begin
                        map_we     = '{used_we: 1'b1, used_val: 1'b0, blk_we: 1'b0};
                        wr_addr    = pidx_reg;
                        tag_next   = tag_eff;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        // block index changed: walk ends
                        iss_next   = '0;
                        state_next = ST_COUNT;
                    end
                end
                else if (!iss_live)
                begin
                    iss_next   = '0;
                    state_next = ST_COUNT;
                end
            end

            ST_COUNT:
            begin
                rd_en = iss_live;
                if (rd_en)
                begin
                    iss_next = iss_reg + NW'(1);
                end
                if (page_free)
                begin
                    cnt_next = cnt_reg + CMPW'(1);
                end
                if (!pv_reg && !iss_live)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_start_next = (func_reg == FUNC_ALLOC && ok_reg)
                                   ? base_reg + FRAME_W'(start_reg) : '0;
                    out_free_next  = cnt_reg[COUNT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // read data only counts inside the state that issued it
        pv_next = rd_en && (state_next == state_reg);
        if (rd_en)
        begin
            pidx_next = iss_reg[PW-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            iss_reg       <= '0;
            pv_reg        <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        func_reg      <= func_next;
        want_reg      <= want_next;
        frame_reg     <= frame_next;
        run_reg       <= run_next;
        start_reg     <= start_next;
        last_reg      <= last_next;
        tag_reg       <= tag_next;
        ok_reg        <= ok_next;
        cnt_reg       <= cnt_next;
        out_ok_reg    <= out_ok_next;
        out_start_reg <= out_start_next;
        out_free_reg  <= out_free_next;
    end

    // configuration writes, taken at any time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            fixed_reg <= FIXED_RESET;
            base_reg  <= BASE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOTAL_PAGES: total_reg <= cfg_data[COUNT_W-1:0];
                CFG_FIXED_PAGES: fixed_reg <= cfg_data[COUNT_W-1:0];
                CFG_BASE_FRAME:  base_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign start_frame = out_start_reg;
    assign free_count  = out_free_reg;

endmodule

// ----- sv/cpa_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the contiguous page allocator, bound to the top level
module cpa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [cpa_pkg::FUNC_W-1:0]      func,
    input logic [cpa_pkg::COUNT_W-1:0]     page_count,
    input logic [cpa_pkg::FRAME_W-1:0]     frame,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            ok,
    input logic [cpa_pkg::FRAME_W-1:0]     start_frame,
    input logic [cpa_pkg::COUNT_W-1:0]     free_count,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [cpa_pkg::FRAME_W-1:0]     cfg_data
);
    import cpa_pkg::*;

    // a held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({ok, start_frame, free_count}))
        else $error("result word changed while stalled");

    // an accepted word keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after accept");

    // a new result only comes out of work in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in work");

    // a failed result carries no frame
    a_frame_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> start_frame == '0)
        else $error("start frame on a failed operation");

endmodule

bind contiguous_page_allocator_core cpa_checker u_cpa_checker (.*);

// ----- tb/sv/page_map_checker.sv -----
`timescale 1ns / 1ps
// page map checker: mirrors the allocator state and compares each result word
module page_map_checker #(
    parameter int NUM_PAGES = cpa_pkg::DEF_NUM_PAGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [cpa_pkg::FUNC_W-1:0]      func,
    input  logic [cpa_pkg::COUNT_W-1:0]     page_count,
    input  logic [cpa_pkg::FRAME_W-1:0]     frame,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            ok,
    input  logic [cpa_pkg::FRAME_W-1:0]     start_frame,
    input  logic [cpa_pkg::COUNT_W-1:0]     free_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cpa_pkg::FRAME_W-1:0]     cfg_data,
    output int                              errors,
    output int                              pending,
    output int                              allocs_granted,
    output int                              frees_hit
);
    import cpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] start_frame;
        logic [COUNT_W-1:0] free_count;
    } outcome_t;

    outcome_t           outcome_q[$];
    bit                 page_busy[NUM_PAGES];
    logic [IDX_W-1:0]   block_owner[NUM_PAGES];
    logic [COUNT_W-1:0] total_cfg;
    logic [COUNT_W-1:0] fixed_cfg;
    logic [FRAME_W-1:0] base_cfg;
    int                 err_n;
    int                 grant_n;
    int                 hit_n;

    // totals above the map size act as the map size
    function automatic int unsigned managed_count();
        if (total_cfg > NUM_PAGES)
            return NUM_PAGES;
        return 32'(total_cfg);
    endfunction

    function automatic bit page_open(int unsigned i);
        return i >= fixed_cfg && !page_busy[i];
    endfunction

    function automatic logic [COUNT_W-1:0] open_pages();
        int unsigned n;
        int unsigned c;
        int unsigned i;
        n = managed_count();
        c = 0;
        for (i = 0; i < n; i++)
            if (page_open(i))
                c++;
        return c[COUNT_W-1:0];
    endfunction

    // applies one request to the mirrored map and returns its result word
    function automatic outcome_t page_map_outcome(func_t op, logic [COUNT_W-1:0] want,
                                                  logic [FRAME_W-1:0] fr);
        outcome_t           r;
        int unsigned        n;
        int unsigned        i;
        int unsigned        run;
        int unsigned        first;
        int unsigned        idx;
        logic [FRAME_W-1:0] offset;
        logic [IDX_W-1:0]   tag;
        bit                 found;
        bit                 managed;
        n       = managed_count();
        r       = '0;
        found   = 1'b0;
        run     = 0;
        first   = 0;
        offset  = fr - base_cfg;
        idx     = 32'(offset);
        managed = idx < n && idx >= fixed_cfg;
        case (op)
            FUNC_ALLOC:
            begin
                // first fit over the managed range
                if (want != 0)
                begin
                    for (i = 0; i < n && !found; i++)
                    begin
                        if (page_open(i))
                        begin
                            if (run == 0)
                                first = i;
                            run++;
                            if (run == want)
                                found = 1'b1;
                        end
                        else
                            run = 0;
                    end
                end
                if (found)
                begin
                    for (i = first; i < first + want; i++)
                    begin
                        page_busy[i]   = 1'b1;
                        block_owner[i] = first[IDX_W-1:0];
                    end
                    r.ok          = 1'b1;
                    r.start_frame = base_cfg + first[FRAME_W-1:0];
                end
            end
            FUNC_FREE_BLOCK:
            begin
                if (managed)
                begin
                    tag  = block_owner[idx];
                    r.ok = 1'b1;
                    // walk while the owner matches, used or not
                    for (i = idx; i < n && block_owner[i] == tag; i++)
                        page_busy[i] = 1'b0;
                end
            end
            FUNC_FREE_ONE:
            begin
                if (managed)
                begin
                    r.ok           = 1'b1;
                    page_busy[idx] = 1'b0;
                end
            end
            default:
                r.ok = 1'b1;
        endcase
        r.free_count = open_pages();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t exp;
        int       k;
        if (!rst_n)
        begin
            outcome_q.delete();
            for (k = 0; k < NUM_PAGES; k++)
            begin
                page_busy[k]   = 1'b0;
                block_owner[k] = '0;
            end
            total_cfg      = TOTAL_RESET;
            fixed_cfg      = FIXED_RESET;
            base_cfg       = BASE_RESET;
            err_n          = 0;
            grant_n        = 0;
            hit_n          = 0;
            errors         <= 0;
            pending        <= 0;
            allocs_granted <= 0;
            frees_hit      <= 0;
        end
        else
        begin
            // result side first: a word leaving now was taken in earlier
            if (out_valid && !out_stall)
            begin
                got = {ok, start_frame, free_count};
                if (outcome_q.size() == 0)
                begin
                    err_n++;
                    if (err_n <= 10)
                        $display("mismatch at %0t: unexpected ok=%0d start=%05h free=%0d",
                                 $realtime, got.ok, got.start_frame, got.free_count);
                end
                else
                begin
                    exp = outcome_q.pop_front();
                    if (got.ok !== exp.ok || got.start_frame !== exp.start_frame ||
                        got.free_count !== exp.free_count)
                    begin
                        err_n++;
                        if (err_n <= 10)
                        begin
                            $display("mismatch at %0t: expected ok=%0d start=%05h free=%0d",
                                     $realtime, exp.ok, exp.start_frame, exp.free_count);
                            $display("    actual ok=%0d start=%05h free=%0d",
                                     got.ok, got.start_frame, got.free_count);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                exp = page_map_outcome(func_t'(func), page_count, frame);
                outcome_q.push_back(exp);
                if (exp.ok && func_t'(func) == FUNC_ALLOC)
                    grant_n++;
                if (exp.ok && (func_t'(func) inside {FUNC_FREE_BLOCK, FUNC_FREE_ONE}))
                    hit_n++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TOTAL_PAGES: total_cfg = cfg_data[COUNT_W-1:0];
                    CFG_FIXED_PAGES: fixed_cfg = cfg_data[COUNT_W-1:0];
                    CFG_BASE_FRAME:  base_cfg  = cfg_data;
                    default:         ;
                endcase
            end
            errors         <= err_n;
            pending        <= outcome_q.size();
            allocs_granted <= grant_n;
            frees_hit      <= hit_n;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, request and register stimulus, and the verdict
module testbench;
    import cpa_pkg::*;

    localparam int NUM_PAGES   = DEF_NUM_PAGES;
    // limit covers the slowest op over 1024 pages, a few hundred words, random stalls
    localparam int CYCLE_LIMIT = 2_000_000;
    // percent of cycles in which a side idles or stalls
    localparam int IDLE_PCT    = 34;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [FUNC_W-1:0]    func;
    logic [COUNT_W-1:0]   page_count;
    logic [FRAME_W-1:0]   frame;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 ok;
    logic [FRAME_W-1:0]   start_frame;
    logic [COUNT_W-1:0]   free_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FRAME_W-1:0]   cfg_data;

    // high during the stretch where neither side idles
    logic                 quiet = 1'b0;
    int                   cycles = 0;
    int                   words_sent = 0;
    int                   settings_used = 0;
    int                   errors;
    int                   pending;
    int                   allocs_granted;
    int                   frees_hit;

    contiguous_page_allocator_core #(.NUM_PAGES(NUM_PAGES)) u_dut (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .func,
        .page_count,
        .frame,
        .out_valid,
        .out_stall,
        .ok,
        .start_frame,
        .free_count,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    // watches all three channels, mirrors the map, counts mismatches
    page_map_checker #(.NUM_PAGES(NUM_PAGES)) u_check (
        .clk,
        .rst_n,
        .in_valid,
        .in_stall,
        .func,
        .page_count,
        .frame,
        .out_valid,
        .out_stall,
        .ok,
        .start_frame,
        .free_count,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .errors,
        .pending,
        .allocs_granted,
        .frees_hit
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure, off during the quiet stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // hard stop in case a word never comes back
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one request word; valid stays up after acceptance so back-to-back words
    // need no second assignment in the same step, the caller drops it at the end
    task automatic send_word(func_t op, logic [COUNT_W-1:0] want, logic [FRAME_W-1:0] fr);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        page_count <= want;
        frame      <= fr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // register write word; cfg_valid is dropped by the caller after the last one
    task automatic write_reg(cfg_index_t idx, logic [FRAME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // wait until every predicted result word has come back
    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // registers change only with the block idle
    task automatic configure(logic [COUNT_W-1:0] total, logic [COUNT_W-1:0] fixed,
                             logic [FRAME_W-1:0] base, logic calm);
        drain();
        write_reg(CFG_TOTAL_PAGES, FRAME_W'(total));
        write_reg(CFG_FIXED_PAGES, FRAME_W'(fixed));
        write_reg(CFG_BASE_FRAME, base);
        cfg_valid <= 1'b0;
        quiet     <= calm;
        settings_used++;
    endtask

    // mostly well-formed traffic: small runs and frees that land on managed
    // pages, with some foreign frames, oversize requests and random noise
    task automatic random_words(int n, int unsigned total, logic [FRAME_W-1:0] base);
        int unsigned        managed;
        int unsigned        roll;
        int unsigned        span;
        logic [COUNT_W-1:0] want;
        logic [FRAME_W-1:0] fr;
        func_t              op;
        managed = (total > NUM_PAGES) ? NUM_PAGES : total;
        span    = managed / 4 + 1;
        repeat (n)
        begin
            roll = $urandom_range(0, 99);
            want = COUNT_W'($urandom_range(1, span));
            if ($urandom_range(0, 9) == 0)
                fr = FRAME_W'($urandom);
            else
                fr = base + FRAME_W'($urandom_range(0, managed + 3));
            if (roll < 45)
            begin
                op = FUNC_ALLOC;
                if ($urandom_range(0, 15) == 0)
                    want = COUNT_W'($urandom_range(0, 1024));
            end
            else if (roll < 70)
                op = FUNC_FREE_BLOCK;
            else if (roll < 85)
                op = FUNC_FREE_ONE;
            else if (roll < 95)
                op = FUNC_COUNT;
            else
            begin
                op   = func_t'($urandom_range(0, 3));
                want = COUNT_W'($urandom_range(0, 1024));
                fr   = FRAME_W'($urandom);
            end
            send_word(op, want, fr);
        end
        in_valid <= 1'b0;
    endtask

    logic [FRAME_W-1:0] rand_base;

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = FUNC_COUNT;
        page_count = '0;
        frame      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TOTAL_PAGES;
        cfg_data   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at reset settings: 1024 pages, none fixed, base 0
        send_word(FUNC_COUNT, 11'd0, 20'd0);
        send_word(FUNC_ALLOC, 11'd0, 20'd0);         // zero count always fails
        send_word(FUNC_ALLOC, 11'd1, 20'd0);
        send_word(FUNC_ALLOC, 11'd3, 20'd0);
        send_word(FUNC_ALLOC, 11'd1024, 20'd0);      // no run long enough
        send_word(FUNC_FREE_ONE, 11'd0, 20'd2);      // hole inside a block
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'd1);    // walk passes the hole
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'd0);
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'd500);  // walk over free pages to the end
        send_word(FUNC_FREE_ONE, 11'd0, 20'd1024);   // frame past the managed range
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'hFFFFF);
        send_word(FUNC_ALLOC, 11'd1024, 20'd0);      // whole map
        send_word(FUNC_ALLOC, 11'd1, 20'd0);
        send_word(FUNC_COUNT, 11'd0, 20'd0);
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'd0);    // walk stops at the total
        send_word(FUNC_ALLOC, 11'd1023, 20'd0);
        send_word(FUNC_ALLOC, 11'd2, 20'd0);
        send_word(FUNC_ALLOC, 11'd1, 20'd0);         // last page
        send_word(FUNC_FREE_ONE, 11'd0, 20'd1023);
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'd512);
        send_word(FUNC_ALLOC, 11'd600, 20'd0);
        send_word(FUNC_COUNT, 11'd0, 20'd0);
        in_valid <= 1'b0;

        // small map with no idling on either side
        configure(11'd16, 11'd0, 20'd0, 1'b1);
        random_words(50, 16, 20'd0);

        // fixed pages and a base that wraps past the top frame
        configure(11'd40, 11'd3, 20'hFFFF0, 1'b0);
        send_word(FUNC_FREE_ONE, 11'd0, 20'hFFFF1);   // fixed page
        send_word(FUNC_FREE_BLOCK, 11'd0, 20'hFFFF0); // fixed page
        send_word(FUNC_ALLOC, 11'd40, 20'd0);         // larger than the free part
        random_words(60, 40, 20'hFFFF0);

        rand_base = FRAME_W'($urandom);
        configure(11'd64, 11'd10, rand_base, 1'b0);
        random_words(55, 64, rand_base);

        // empty map: nothing is managed
        rand_base = FRAME_W'($urandom);
        configure(11'd0, 11'd0, rand_base, 1'b0);
        random_words(10, 0, rand_base);

        // every page fixed
        rand_base = FRAME_W'($urandom);
        configure(11'd20, 11'd1024, rand_base, 1'b0);
        random_words(10, 20, rand_base);

        // full map at the top base, so frames wrap
        configure(11'd1024, 11'd0, 20'hFFFFF, 1'b0);
        random_words(20, 1024, 20'hFFFFF);

        // shrunk again: marks beyond the total stay but are ignored
        rand_base = FRAME_W'($urandom);
        configure(11'd33, 11'd5, rand_base, 1'b0);
        random_words(60, 33, rand_base);

        // let the slowest op finish in case a stray word is still coming
        drain();
        repeat (3 * NUM_PAGES + 16) @(posedge clk);

        $display("run covered %0d request words under %0d register settings",
                 words_sent, settings_used);
        $display("%0d allocations granted, %0d frees on managed pages, %0d mismatches",
                 allocs_granted, frees_hit, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- contiguous_page_allocator_core.f -----
sv/cpa_pkg.sv
sv/cpa_page_map.sv
sv/contiguous_page_allocator_core.sv
sv/cpa_checker.sv
tb/sv/page_map_checker.sv
tb/sv/testbench.sv
